// ===== hdl/ffha_pkg.sv =====
package ffha_pkg;

  localparam int unsigned OFS_W = 24;
  localparam int unsigned LEN_W = 24;
  localparam int unsigned ADDR_W = 32;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_REGION_BASE = 1'b0,
    CFG_REGION_SIZE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [0:0]  operation;
    logic [23:0] request_size;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [31:0] pointer;
    logic [1:0]  status;
    logic [23:0] used_bytes;
  } rsp_t;

  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic             is_free;
  } entry_t;

endpackage

// ===== hdl/ffha_table.sv =====
module ffha_table import ffha_pkg::*; #(
  parameter int unsigned IDX_W = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [2**IDX_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// First-fit heap allocator over one region, kept as an address-ordered block table
// in a memory with one write port and one registered read port. One sequencer walks
// the table entry by entry (address, then compare). An allocate scans for
// the first fitting free block and, on a split, moves the tail up by one entry
// before writing the two halves. A free scans for its block, checks the next and
// previous neighbours, writes the merged entry back, then moves the tail down by the
// number of entries merged away. A result, once offered, waits for out_ready, and
// in_ready stays low until it is taken. Writing region_size reinitializes the table
// to one free block, or to no blocks if region_size does not exceed HEADER_BYTES.
// Writing region_base only offsets returned pointers and the addresses frees match.
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_BLOCKS);
  localparam logic [LEN_W:0] HDR = (LEN_W+1)'(HEADER_BYTES);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN, S_CHK, S_UP_RD, S_UP_WR, S_SPLIT, S_MARK,
    S_NX_RD, S_NX_CHK, S_PV_RD, S_PV_CHK, S_WB, S_DN_RD, S_DN_WR, S_OUT
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] region_base;
  logic [LEN_W-1:0]  region_size;
  logic [CNT_W-1:0]  count;
  logic [LEN_W-1:0]  used_total;
  req_t              req;
  logic [LEN_W:0]    sz;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  ptr;
  logic [1:0]        gap;
  entry_t            cur;
  logic              nx_merge;
  logic              pv_merge;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;
  entry_t            wdata;
  entry_t            rdata;
  logic [ADDR_W-1:0] paddr;
  logic [LEN_W:0]    sz_full;

  ffha_table #(.IDX_W(IDX_W)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign paddr = region_base + ADDR_W'(rdata.offset) + ADDR_W'(HEADER_BYTES);
  assign sz_full = ({1'b0, in_data.request_size} + (LEN_W+1)'(7)) & ~(LEN_W+1)'(7);

  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);

  // table port control
  always_comb begin
    we = 1'b0;
    waddr = IDX_W'(idx);
    wdata = cur;
    raddr = IDX_W'(idx);
    unique case (state)
      S_INIT: begin
        we = 1'b1;
        waddr = '0;
        wdata = '{offset: '0, length: region_size - LEN_W'(HEADER_BYTES), is_free: 1'b1};
      end
      S_UP_RD: raddr = IDX_W'(ptr);
      S_UP_WR: begin
        we = 1'b1;
        waddr = IDX_W'(ptr + CNT_W'(1));
        wdata = rdata;
      end
      S_SPLIT: begin
        we = 1'b1;
        waddr = IDX_W'(idx + CNT_W'(1));
        wdata = '{offset: cur.offset + OFS_W'(HEADER_BYTES) + sz[OFS_W-1:0],
                  length: cur.length - sz[LEN_W-1:0] - LEN_W'(HEADER_BYTES),
                  is_free: 1'b1};
      end
      S_MARK: we = 1'b1;
      S_NX_RD: raddr = IDX_W'(idx + CNT_W'(1));
      S_PV_RD: raddr = IDX_W'(idx - CNT_W'(1));
      S_WB: begin
        we = 1'b1;
        waddr = pv_merge ? IDX_W'(idx - CNT_W'(1)) : IDX_W'(idx);
      end
      S_DN_RD: raddr = IDX_W'(ptr + CNT_W'(gap));
      S_DN_WR: begin
        we = 1'b1;
        waddr = IDX_W'(ptr);
        wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      region_base <= '0;
      region_size <= LEN_W'(65536);
      used_total <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          count <= ({1'b0, region_size} > HDR) ? CNT_W'(1) : '0;
          used_total <= '0;
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_REGION_BASE) begin
              region_base <= cfg_data;
            end else begin
              region_size <= cfg_data[LEN_W-1:0];
              state <= S_INIT;
            end
          end else if (in_valid) begin
            req <= in_data;
            sz <= sz_full;
            idx <= '0;
            nx_merge <= 1'b0;
            pv_merge <= 1'b0;
            out_data.pointer <= '0;
            if (in_data.operation == OP_ALLOC) begin
              out_data.status <= ST_NOFIT;
              state <= (in_data.request_size == '0 || count == '0) ? S_OUT : S_SCAN;
            end else if (in_data.address == '0) begin
              out_data.status <= ST_OK;
              state <= S_OUT;
            end else begin
              out_data.status <= ST_UNKNOWN;
              state <= (count == '0) ? S_OUT : S_SCAN;
            end
          end
        end
        S_SCAN: state <= S_CHK;
        S_CHK: begin
          if (req.operation == OP_ALLOC && rdata.is_free && {1'b0, rdata.length} >= sz) begin
            out_data.pointer <= paddr;
            out_data.status <= ST_OK;
            cur <= '{offset: rdata.offset, length: rdata.length, is_free: 1'b0};
            if ({1'b0, rdata.length} > sz + HDR && count < MAXC) begin
              used_total <= used_total + sz[LEN_W-1:0];
              ptr <= count - CNT_W'(1);
              state <= (count == idx + CNT_W'(1)) ? S_SPLIT : S_UP_RD;
            end else begin
              used_total <= used_total + rdata.length;
              state <= S_MARK;
            end
          end else if (req.operation == OP_FREE && !rdata.is_free &&
                       paddr == req.address) begin
            out_data.status <= ST_OK;
            used_total <= used_total - rdata.length;
            cur <= '{offset: rdata.offset, length: rdata.length, is_free: 1'b1};
            if (idx + CNT_W'(1) < count) begin
              state <= S_NX_RD;
            end else if (idx != '0) begin
              state <= S_PV_RD;
            end else begin
              state <= S_WB;
            end
          end else if (idx + CNT_W'(1) >= count) begin
            state <= S_OUT;
          end else begin
            idx <= idx + CNT_W'(1);
            state <= S_SCAN;
          end
        end
        // split: move entries above idx up by one, from the top down
        S_UP_RD: state <= S_UP_WR;
        S_UP_WR: begin
          if (ptr == idx + CNT_W'(1)) begin
            state <= S_SPLIT;
          end else begin
            ptr <= ptr - CNT_W'(1);
            state <= S_UP_RD;
          end
        end
        S_SPLIT: begin
          cur.length <= sz[LEN_W-1:0];
          count <= count + CNT_W'(1);
          state <= S_MARK;
        end
        S_MARK: state <= S_OUT;
        // merge with free neighbours
        S_NX_RD: state <= S_NX_CHK;
        S_NX_CHK: begin
          if (rdata.is_free) begin
            cur.length <= cur.length + LEN_W'(HEADER_BYTES) + rdata.length;
            nx_merge <= 1'b1;
          end
          state <= (idx != '0) ? S_PV_RD : S_WB;
        end
        S_PV_RD: state <= S_PV_CHK;
        S_PV_CHK: begin
          if (rdata.is_free) begin
            cur <= '{offset: rdata.offset,
                     length: rdata.length + LEN_W'(HEADER_BYTES) + cur.length,
                     is_free: 1'b1};
            pv_merge <= 1'b1;
          end
          state <= S_WB;
        end
        S_WB: begin
          gap <= {1'b0, nx_merge} + {1'b0, pv_merge};
          ptr <= pv_merge ? idx : idx + CNT_W'(1);
          state <= (nx_merge || pv_merge) ? S_DN_RD : S_OUT;
        end
        // delete: copy entry ptr+gap into ptr up to count
        S_DN_RD: begin
          if (ptr + CNT_W'(gap) >= count) begin
            count <= count - CNT_W'(gap);
            state <= S_OUT;
          end else begin
            state <= S_DN_WR;
          end
        end
        S_DN_WR: begin
          ptr <= ptr + CNT_W'(1);
          state <= S_DN_RD;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_data.used_bytes <= used_total;
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> !out_valid)
    else $error("result without work");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) count <= MAXC)
    else $error("table overflow");

endmodule
